// File: sv/fmrc_pkg.sv
// ----------------------------------------------------------------------------
// fmrc_pkg
// Shared types, codes and the CRC-16/MCRF4XX byte step for the frame receiver.
// ----------------------------------------------------------------------------
package fmrc_pkg;

    localparam int MAX_PAYLOAD_DEF = 256;
    localparam logic [7:0]  START_MARKER_RST = 8'hFE;
    localparam logic [15:0] CRC_SEED = 16'hFFFF;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_GOOD     = 2'd1;
    localparam logic [1:0] KIND_BAD_CRC  = 2'd2;
    localparam logic [1:0] KIND_TOO_LONG = 2'd3;

    // input beat modes
    localparam logic MODE_BYTE    = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [15:0] frame_length;
        logic [7:0]  heartbeat;
        logic [7:0]  system_id;
        logic [7:0]  component_id;
        logic [7:0]  message_id;
        logic [15:0] computed_crc;
        logic        frame_end;
    } result_t;

    // reflected poly 0x1021, one byte per call
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        begin
            t = b ^ crc[7:0];
            t = t ^ {t[3:0], 4'b0000};
            crc_step = {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000}
                       ^ {12'h000, t[7:4]};
        end
    endfunction

endpackage

// File: sv/framed_message_receiver_crc16_unit.sv
// ----------------------------------------------------------------------------
// framed_message_receiver_crc16_unit
// Byte-stream frame parser with CRC-16/MCRF4XX check and payload streaming.
// ----------------------------------------------------------------------------
// Feed received bytes on the slave stream (tuser = 0) one beat each. The unit
// hunts for the start marker, then reads a big-endian 16-bit length, the
// heartbeat, system, component and message id bytes, the payload and a
// CRC sent low byte first. Each payload byte comes out as a kind-0 beat; the
// frame closes with a good, bad-CRC or too-long beat with tlast set. After a
// good frame the parser ignores bytes until a release beat (tuser = 1) is
// sent. Beats are taken back to back, one per cycle, while the single output
// register can take a result: parse step and CRC byte update sit between the
// parse state and that register, and a beat is accepted whenever it is empty
// or being drained in the same cycle. A result appears on the master side the
// cycle after its beat. The user writes the start marker (reset 0xFE) through
// cfg_we/cfg_wdata only while the stream is idle; the unit does not check it.
// ----------------------------------------------------------------------------
module framed_message_receiver_crc16_unit #(
    parameter int MAX_PAYLOAD = fmrc_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,   // start_marker
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] rx_byte
    input  logic        s_tuser,     // [0] mode
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] payload_byte, [15:8] payload_index, [31:16] frame_length,
    // [39:32] heartbeat, [47:40] system_id, [55:48] component_id,
    // [63:56] message_id, [79:64] computed_crc
    output logic [79:0] m_tdata,
    output logic [1:0]  m_tuser,     // [1:0] kind
    output logic        m_tlast      // frame_end
);
    import fmrc_pkg::*;

    logic [7:0] marker_reg;
    logic       accept;
    logic       res_valid;
    result_t    res;
    result_t    out_reg;
    logic       out_valid_reg;

    // start marker register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            marker_reg <= START_MARKER_RST;
        else if (cfg_we)
            marker_reg <= cfg_wdata;
    end

    // take a beat when the output slot is free or freeing this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    fmrc_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .mode         (s_tuser),
        .rx_byte      (s_tdata),
        .start_marker (marker_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && res_valid)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
            out_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.frame_end;
    assign m_tdata  = {out_reg.computed_crc, out_reg.message_id, out_reg.component_id,
                       out_reg.system_id, out_reg.heartbeat, out_reg.frame_length,
                       out_reg.payload_index, out_reg.payload_byte};

endmodule

// File: sv/fmrc_parser.sv
// ----------------------------------------------------------------------------
// fmrc_parser
// Frame parse state, CRC accumulation and per-beat result generation.
// ----------------------------------------------------------------------------
module fmrc_parser #(
    parameter int MAX_PAYLOAD = fmrc_pkg::MAX_PAYLOAD_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              mode,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        start_marker,
    output logic              res_valid,
    output fmrc_pkg::result_t res
);
    import fmrc_pkg::*;

    localparam logic [3:0] PH_HUNT   = 4'd0;
    localparam logic [3:0] PH_LEN_HI = 4'd1;
    localparam logic [3:0] PH_LEN_LO = 4'd2;
    localparam logic [3:0] PH_HEART  = 4'd3;
    localparam logic [3:0] PH_SYS    = 4'd4;
    localparam logic [3:0] PH_COMP   = 4'd5;
    localparam logic [3:0] PH_MSG    = 4'd6;
    localparam logic [3:0] PH_DATA   = 4'd7;
    localparam logic [3:0] PH_CRC_LO = 4'd8;
    localparam logic [3:0] PH_CRC_HI = 4'd9;

    localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [7:0]  hb_reg, hb_next;
    logic [7:0]  sys_reg, sys_next;
    logic [7:0]  comp_reg, comp_next;
    logic [7:0]  msg_reg, msg_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic [15:0] crc_reg, crc_next;
    logic        hold_reg, hold_next;

    logic [15:0] crc_upd;
    logic [15:0] len_full;

    assign crc_upd  = crc_step(crc_reg, rx_byte);
    assign len_full = {len_reg[15:8], rx_byte};

    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        cnt_next    = cnt_reg;
        hb_next     = hb_reg;
        sys_next    = sys_reg;
        comp_next   = comp_reg;
        msg_next    = msg_reg;
        crc_lo_next = crc_lo_reg;
        crc_next    = crc_reg;
        hold_next   = hold_reg;
        res_valid   = 1'b0;

        res.kind          = KIND_PAYLOAD;
        res.payload_byte  = 8'h00;
        res.payload_index = 8'h00;
        res.frame_length  = len_reg;
        res.heartbeat     = hb_reg;
        res.system_id     = sys_reg;
        res.component_id  = comp_reg;
        res.message_id    = msg_reg;
        res.computed_crc  = 16'h0000;
        res.frame_end     = 1'b0;

        if (mode == MODE_RELEASE)
        begin
            if (hold_reg)
            begin
                hold_next  = 1'b0;
                phase_next = PH_HUNT;
            end
        end
        else if (!hold_reg)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == start_marker)
                    begin
                        crc_next   = CRC_SEED;
                        phase_next = PH_LEN_HI;
                    end
                end
                PH_LEN_HI:
                begin
                    crc_next   = crc_upd;
                    len_next   = {rx_byte, 8'h00};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    crc_next = crc_upd;
                    len_next = len_full;
                    if ({1'b0, len_full} > MAX_LEN)
                    begin
                        phase_next         = PH_HUNT;
                        res_valid          = 1'b1;
                        res.kind           = KIND_TOO_LONG;
                        res.frame_length   = len_full;
                        res.heartbeat      = 8'h00;
                        res.system_id      = 8'h00;
                        res.component_id   = 8'h00;
                        res.message_id     = 8'h00;
                        res.frame_end      = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_HEART;
                    end
                end
                PH_HEART:
                begin
                    crc_next   = crc_upd;
                    hb_next    = rx_byte;
                    phase_next = PH_SYS;
                end
                PH_SYS:
                begin
                    crc_next   = crc_upd;
                    sys_next   = rx_byte;
                    phase_next = PH_COMP;
                end
                PH_COMP:
                begin
                    crc_next   = crc_upd;
                    comp_next  = rx_byte;
                    phase_next = PH_MSG;
                end
                PH_MSG:
                begin
                    crc_next   = crc_upd;
                    msg_next   = rx_byte;
                    cnt_next   = 16'h0000;
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    if (cnt_reg < len_reg)
                    begin
                        crc_next          = crc_upd;
                        cnt_next          = cnt_reg + 16'd1;
                        res_valid         = 1'b1;
                        res.kind          = KIND_PAYLOAD;
                        res.payload_byte  = rx_byte;
                        res.payload_index = cnt_reg[7:0];
                    end
                    else
                    begin
                        // zero remaining: this byte is the CRC low byte
                        crc_lo_next = rx_byte;
                        phase_next  = PH_CRC_HI;
                    end
                end
                PH_CRC_LO:
                begin
                    crc_lo_next = rx_byte;
                    phase_next  = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    phase_next       = PH_HUNT;
                    res_valid        = 1'b1;
                    res.computed_crc = crc_reg;
                    res.frame_end    = 1'b1;
                    if (crc_lo_reg == crc_reg[7:0] && rx_byte == crc_reg[15:8])
                    begin
                        hold_next = 1'b1;
                        res.kind  = KIND_GOOD;
                    end
                    else
                    begin
                        res.kind = KIND_BAD_CRC;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            len_reg    <= 16'h0000;
            cnt_reg    <= 16'h0000;
            hb_reg     <= 8'h00;
            sys_reg    <= 8'h00;
            comp_reg   <= 8'h00;
            msg_reg    <= 8'h00;
            crc_lo_reg <= 8'h00;
            crc_reg    <= CRC_SEED;
            hold_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            cnt_reg    <= cnt_next;
            hb_reg     <= hb_next;
            sys_reg    <= sys_next;
            comp_reg   <= comp_next;
            msg_reg    <= msg_next;
            crc_lo_reg <= crc_lo_next;
            crc_reg    <= crc_next;
            hold_reg   <= hold_next;
        end
    end

endmodule
